### src/erm_pkg.sv
// Package for the Euler rotation matrix block: request and result types,
// CORDIC constants and the arctangent table. No dependencies.
package erm_pkg;

  localparam int AngleW = 16;
  localparam int CoefW = 16;
  localparam int DataW = 34;
  localparam int PhaseW = 32;
  localparam logic signed [DataW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [DataW-1:0] QOne = 34'sd1073741824;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic signed [PhaseW:0] phase_t;

  typedef struct packed {
    logic signed [AngleW-1:0] yaw_angle;
    logic signed [AngleW-1:0] pitch_angle;
    logic signed [AngleW-1:0] roll_angle;
  } request_t;

  typedef struct packed {
    logic signed [CoefW-1:0] entry_00;
    logic signed [CoefW-1:0] entry_01;
    logic signed [CoefW-1:0] entry_02;
    logic signed [CoefW-1:0] entry_10;
    logic signed [CoefW-1:0] entry_11;
    logic signed [CoefW-1:0] entry_12;
    logic signed [CoefW-1:0] entry_20;
    logic signed [CoefW-1:0] entry_21;
    logic signed [CoefW-1:0] entry_22;
  } result_t;

  // Three angles travelling down the CORDIC chain.
  typedef struct packed {
    data_t  [2:0] x;
    data_t  [2:0] y;
    phase_t [2:0] z;
    logic   [2:0][1:0] quad;
  } cordic_t;

  function automatic phase_t atan_entry(input int i);
    logic [31:0] v;
    begin
      unique case (i)
        0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
        3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
        6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
        9: v = 32'h00145F2F; 10: v = 32'h000A2F98; 11: v = 32'h000517CC;
        12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
        15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
        18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
        21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
        24: v = 32'h00000029; 25: v = 32'h00000014; 26: v = 32'h0000000A;
        27: v = 32'h00000005; 28: v = 32'h00000003; 29: v = 32'h00000001;
        30: v = 32'h00000001;
        default: v = 32'h00000000;
      endcase
      atan_entry = {1'b0, v};
    end
  endfunction

endpackage

### src/erm_cell.sv
// One CORDIC micro-rotation cell for three angles at once.
// Depends on erm_pkg.
module erm_cell import erm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    in_valid,
  input  cordic_t in_data,
  output logic    out_valid,
  output cordic_t out_data
);

  localparam int Shift = (STEP > DataW - 1) ? DataW - 1 : STEP;
  localparam phase_t Atan = atan_entry(STEP);

  cordic_t data_next;

  always_comb begin
    data_next = in_data;
    for (int a = 0; a < 3; a++) begin
      if (!in_data.z[a][PhaseW]) begin
        data_next.x[a] = in_data.x[a] - (in_data.y[a] >>> Shift);
        data_next.y[a] = in_data.y[a] + (in_data.x[a] >>> Shift);
        data_next.z[a] = in_data.z[a] - Atan;
      end else begin
        data_next.x[a] = in_data.x[a] + (in_data.y[a] >>> Shift);
        data_next.y[a] = in_data.y[a] - (in_data.x[a] >>> Shift);
        data_next.z[a] = in_data.z[a] + Atan;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

### src/erm_matrix.sv
// Matrix stage: turns sines and cosines into the rotation product and
// rounds to the output format. Depends on erm_pkg.
module erm_matrix import erm_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    in_valid,
  input  cordic_t in_data,
  output logic    out_valid,
  output result_t out_data
);

  typedef logic signed [2*DataW+1:0] wide_t;

  data_t [2:0] cs, sn;
  data_t cy, sy, cp, sp, cr, sr;
  logic v1, v2, v3;
  data_t [8:0] t;
  data_t [8:0] m;
  wide_t [8:0] p;
  data_t ry_cy, ry_sy;
  logic [8:0][CoefW-1:0] o;

  function automatic data_t rnd(input wide_t acc);
    wide_t s;
    begin
      s = (acc + (wide_t'(1) <<< 29)) >>> 30;
      rnd = s[DataW-1:0];
    end
  endfunction

  function automatic logic [CoefW-1:0] to_out(input data_t v);
    logic signed [DataW:0] r, lim;
    begin
      lim = (DataW+1)'(1) <<< COEF_FRAC_BITS;
      if (COEF_FRAC_BITS < 30) begin
        r = ($signed({v[DataW-1], v}) + ((DataW+1)'(1) <<< (29 - COEF_FRAC_BITS)))
            >>> (30 - COEF_FRAC_BITS);
      end else begin
        r = $signed({v[DataW-1], v});
      end
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      to_out = r[CoefW-1:0];
    end
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (in_data.quad[a])
        2'd0: begin cs[a] = in_data.x[a];  sn[a] = in_data.y[a];  end
        2'd1: begin cs[a] = -in_data.y[a]; sn[a] = in_data.x[a];  end
        2'd2: begin cs[a] = -in_data.x[a]; sn[a] = -in_data.y[a]; end
        default: begin cs[a] = in_data.y[a]; sn[a] = -in_data.x[a]; end
      endcase
    end
    cy = cs[0]; sy = sn[0]; cp = cs[1]; sp = sn[1]; cr = cs[2]; sr = sn[2];
  end

  // Stage one: T = Rz * Rx.
  data_t [8:0] t_next;
  always_comb begin
    t_next[0] = rnd(wide_t'(cr) * wide_t'(QOne));
    t_next[1] = rnd(-(wide_t'(sr) * wide_t'(cp)));
    t_next[2] = rnd(wide_t'(sr) * wide_t'(sp));
    t_next[3] = rnd(wide_t'(sr) * wide_t'(QOne));
    t_next[4] = rnd(wide_t'(cr) * wide_t'(cp));
    t_next[5] = rnd(-(wide_t'(cr) * wide_t'(sp)));
    t_next[6] = '0;
    t_next[7] = rnd(wide_t'(QOne) * wide_t'(sp));
    t_next[8] = rnd(wide_t'(QOne) * wide_t'(cp));
  end

  // Stage two: M = T * Ry, Ry being [[c,0,s],[0,1,0],[-s,0,c]].
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      p[3*r]   = wide_t'(t[3*r]) * wide_t'(ry_cy) - wide_t'(t[3*r+2]) * wide_t'(ry_sy);
      p[3*r+1] = wide_t'(t[3*r+1]) * wide_t'(QOne);
      p[3*r+2] = wide_t'(t[3*r]) * wide_t'(ry_sy) + wide_t'(t[3*r+2]) * wide_t'(ry_cy);
    end
    for (int k = 0; k < 9; k++) begin
      o[k] = to_out(m[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    if (advance) begin
      t <= t_next;
      ry_cy <= cy;
      ry_sy <= sy;
      for (int k = 0; k < 9; k++) m[k] <= rnd(p[k]);
      out_data <= {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
    end
  end

  assign out_valid = v3;

endmodule

### src/euler_rotation_matrix.sv
// Euler rotation matrix top level: Z-X-Y product of three CORDIC rotations.
// Depends on erm_pkg, erm_cell and erm_matrix.
//
// A request carries yaw, pitch and roll as binary angles. One result holds
// the nine entries of Rz(roll)*Rx(pitch)*Ry(yaw) in signed Q1.14.
// The request channel is in_valid/in_stall with payload in_data, the result
// channel out_valid/out_stall with payload out_data.
// The pipeline is one input register, one cell per CORDIC step (at most 32)
// and three matrix stages. One request enters every cycle while not stalled.
// The whole pipeline advances together; when the receiver stalls a held
// result, the pipeline freezes and in_stall is raised, so nothing is lost.
// Reset clears all valid flags; payload registers are not reset.
module euler_rotation_matrix import erm_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int COEF_FRAC_BITS = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  request_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  out_data
);

  localparam int Steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic advance;
  logic [Steps:0] vchain;
  cordic_t [Steps:0] dchain;
  cordic_t head;
  logic [2:0][AngleW-1:0] ang;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign ang = {in_data.roll_angle, in_data.pitch_angle, in_data.yaw_angle};

  always_comb begin
    logic [PhaseW-1:0] ph, zu;
    logic [1:0] q;
    head = '0;
    for (int a = 0; a < 3; a++) begin
      ph = PhaseW'({{(PhaseW-AngleW){ang[a][AngleW-1]}}, ang[a]} << (PhaseW - ANGLE_BITS));
      zu = ph + 32'h20000000;
      q = zu[PhaseW-1:PhaseW-2];
      zu = ph - {q, 30'b0};
      head.x[a] = CordicGain;
      head.y[a] = '0;
      head.z[a] = {zu[PhaseW-1], zu};
      head.quad[a] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vchain[0] <= 1'b0;
    end else if (advance) begin
      vchain[0] <= in_valid;
    end
    if (advance) begin
      dchain[0] <= head;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_cell
    erm_cell #(.STEP(i)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .in_valid(vchain[i]), .in_data(dchain[i]),
      .out_valid(vchain[i+1]), .out_data(dchain[i+1])
    );
  end

  erm_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(vchain[Steps]), .in_data(dchain[Steps]),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule

### verif/tb_euler_rotation_matrix.sv
// Testbench for euler_rotation_matrix: drives angle triples with random idling on both
// channels and checks every rotation matrix against a fixed-point CORDIC predictor.
// Depends on erm_pkg and euler_rotation_matrix.
module tb_euler_rotation_matrix;
  import erm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint QuarterOne = 64'sd1073741824;
  localparam longint GainQ30 = 64'sd652032874;
  localparam longint CoefLim = 64'sd16384;

  class matrix_scoreboard;
    result_t pending[$];
    int errors = 0;
    longint arctan[16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

    function void sin_cos(logic signed [15:0] ang, output longint c, output longint s);
      logic [31:0] ph, zu;
      logic [1:0] quad;
      longint x, y, z, nx;
      ph = {ang, 16'h0000};
      quad = 2'((ph + 32'h2000_0000) >> 30);
      zu = ph - {quad, 30'b0};
      z = longint'(signed'(zu));
      x = GainQ30;
      y = 0;
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z = z - arctan[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z = z + arctan[i];
        end
        x = nx;
      end
      case (quad)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic signed [15:0] to_coef(longint v);
      longint r;
      r = (v + 64'sd32768) >>> 16;
      if (r > CoefLim) r = CoefLim;
      if (r < -CoefLim) r = -CoefLim;
      return r[15:0];
    endfunction

    function void note(request_t req);
      longint cy, sy, cp, sp, cr, sr, acc;
      longint rz[3][3], rx[3][3], ry[3][3], t[3][3], m[3][3];
      result_t res;
      sin_cos(req.yaw_angle, cy, sy);
      sin_cos(req.pitch_angle, cp, sp);
      sin_cos(req.roll_angle, cr, sr);
      rz = '{'{cr, -sr, 0}, '{sr, cr, 0}, '{0, 0, QuarterOne}};
      rx = '{'{QuarterOne, 0, 0}, '{0, cp, -sp}, '{0, sp, cp}};
      ry = '{'{cy, 0, sy}, '{0, QuarterOne, 0}, '{-sy, 0, cy}};
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rz[i][k] * rx[k][j];
          t[i][j] = (acc + (64'sd1 << 29)) >>> 30;
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += t[i][k] * ry[k][j];
          m[i][j] = (acc + (64'sd1 << 29)) >>> 30;
        end
      res.entry_00 = to_coef(m[0][0]);
      res.entry_01 = to_coef(m[0][1]);
      res.entry_02 = to_coef(m[0][2]);
      res.entry_10 = to_coef(m[1][0]);
      res.entry_11 = to_coef(m[1][1]);
      res.entry_12 = to_coef(m[1][2]);
      res.entry_20 = to_coef(m[2][0]);
      res.entry_21 = to_coef(m[2][1]);
      res.entry_22 = to_coef(m[2][2]);
      pending.push_back(res);
    endfunction

    task report(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 0, 0);
        return;
      end
      want = pending.pop_front();
      if (got.entry_00 !== want.entry_00) report("entry_00", got.entry_00, want.entry_00);
      if (got.entry_01 !== want.entry_01) report("entry_01", got.entry_01, want.entry_01);
      if (got.entry_02 !== want.entry_02) report("entry_02", got.entry_02, want.entry_02);
      if (got.entry_10 !== want.entry_10) report("entry_10", got.entry_10, want.entry_10);
      if (got.entry_11 !== want.entry_11) report("entry_11", got.entry_11, want.entry_11);
      if (got.entry_12 !== want.entry_12) report("entry_12", got.entry_12, want.entry_12);
      if (got.entry_20 !== want.entry_20) report("entry_20", got.entry_20, want.entry_20);
      if (got.entry_21 !== want.entry_21) report("entry_21", got.entry_21, want.entry_21);
      if (got.entry_22 !== want.entry_22) report("entry_22", got.entry_22, want.entry_22);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  request_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_data;
  bit steady = 1'b0;
  matrix_scoreboard sb = new();

  euler_rotation_matrix i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check(out_data);
      out_stall <= !steady && ($urandom_range(99) < 28);
    end
  end

  task send(request_t req);
    in_data <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note(req);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task send_angles(int yaw, int pitch, int roll);
    request_t req;
    req.yaw_angle = yaw[15:0];
    req.pitch_angle = pitch[15:0];
    req.roll_angle = roll[15:0];
    send(req);
  endtask

  function automatic int pick_angle();
    int edges[10] = '{0, 8192, -8192, 16384, -16384, 24576, -24576, -32768, 8191, 32767};
    if ($urandom_range(99) < 20) return edges[$urandom_range(9)] + $urandom_range(2) - 1;
    return $urandom_range(65535);
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_angles(0, 0, 0);
    send_angles(32767, 32767, 32767);
    send_angles(-32768, -32768, -32768);
    send_angles(-1, -1, -1);
    send_angles(16384, 0, 0);
    send_angles(0, 16384, 0);
    send_angles(0, 0, 16384);
    send_angles(-16384, -16384, -16384);
    send_angles(8192, 8192, 8192);
    send_angles(-8192, -8192, -8192);
    send_angles(8191, 24575, 24576);
    send_angles(-8193, -24577, -24576);
    send_angles(1, -32768, 32767);
    send_angles(16383, 16385, -16385);
    send_angles(21845, -10923, 5461);
    for (int n = 0; n < 850; n++) begin
      steady = (n >= 300 && n < 420);
      send_angles(pick_angle(), pick_angle(), pick_angle());
    end
    steady = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("euler_rotation_matrix verification clean");
    end else begin
      $display("euler_rotation_matrix verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("euler_rotation_matrix verification failed");
    $finish;
  end
endmodule

### sim.f
src/erm_pkg.sv
src/erm_cell.sv
src/erm_matrix.sv
src/euler_rotation_matrix.sv
verif/tb_euler_rotation_matrix.sv
